[rtl/midi_note_tracker_highest_priority_top_defines.svh]
// Assertion macros for the MIDI note tracker.
`ifndef MIDI_NOTE_TRACKER_HIGHEST_PRIORITY_TOP_DEFINES_SVH
`define MIDI_NOTE_TRACKER_HIGHEST_PRIORITY_TOP_DEFINES_SVH
`ifndef SYNTH
// ante implies cons in the same cycle
`define NMT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("note tracker check failed");
// ante implies cons in the next cycle
`define NMT_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("note tracker check failed");
`else
`define NMT_ASSERT_IMP(lbl, ante, cons)
`define NMT_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[rtl/nmt_pkg.sv]
// Shared constants and types of the MIDI note tracker.
package nmt_pkg;

	localparam int NOTE_COUNT_DEF = 128;
	localparam int NOTE_W         = 7;
	localparam int VEL_W          = 7;
	localparam int CNT_W          = 8;
	localparam int CHAN_W         = 4;
	localparam int TYPE_W         = 4;

	localparam logic [TYPE_W-1:0] TYPE_NOTE_ON  = 4'd9;
	localparam logic [TYPE_W-1:0] TYPE_NOTE_OFF = 4'd8;
	localparam logic [CNT_W-1:0]  CNT_MAX       = 8'hFF;

	typedef struct packed {
		logic              wr_en;
		logic [NOTE_W-1:0] wr_addr;
		logic [VEL_W-1:0]  wr_data;
		logic              rd_en;
		logic [NOTE_W-1:0] rd_addr;
	} nmt_mem_req_t;

endpackage

[rtl/midi_note_tracker_highest_priority_top.sv]
// Top level of the MIDI note tracker with highest-note priority.
//
//  channel | signals                          | handshake
//  --------+----------------------------------+-------------------------
//  input   | midi_byte                        | in_valid / in_stall
//  result  | current_note, held_count,        | out_valid / out_stall
//          | message_done                     |
//  config  | cfg_data (listen channel)        | cfg_valid / cfg_ready
//
// An item is buffered at acceptance and processed in the next cycle if the tracker is idle
// and the output register is free; its result is then loaded into the output register.
// A note-off that releases the played note scans the velocity memory downward,
// one entry a cycle through its read port, at most as many entries as the released
// note (at most 127). One item is buffered while a result or a scan waits.
// Reset clears the valid bits of the memory at once; no clearing pass.
`include "midi_note_tracker_highest_priority_top_defines.svh"

module midi_note_tracker_highest_priority_top #(
	parameter int NOTE_COUNT = nmt_pkg::NOTE_COUNT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [7:0]                  midi_byte,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [nmt_pkg::NOTE_W-1:0]  current_note,
	output logic [nmt_pkg::CNT_W-1:0]   held_count,
	output logic                        message_done,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [nmt_pkg::CHAN_W-1:0]  cfg_data
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_RD,
		S_CHK
	} state_t;

	state_t                     st_q, st_d;
	logic [7:0]                 in_byte_q;
	logic                       in_full_q;
	logic [nmt_pkg::CHAN_W-1:0] listen_q;
	logic [nmt_pkg::TYPE_W-1:0] msg_q, msg_d;
	logic                       fv_q, fv_d;
	logic [nmt_pkg::NOTE_W-1:0] fval_q, fval_d;
	logic [nmt_pkg::NOTE_W-1:0] played_q, played_d;
	logic [nmt_pkg::CNT_W-1:0]  held_q, held_d;
	logic [nmt_pkg::NOTE_W-1:0] idx_q, idx_d;
	logic                       out_valid_q;
	logic                       out_free;
	logic                       proc;
	logic                       ld_out;
	logic                       done_d;
	logic [nmt_pkg::VEL_W-1:0]  rd_vel;
	nmt_pkg::nmt_mem_req_t      req;

	assign cfg_ready = 1'b1;
	assign in_stall  = in_full_q;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign proc      = (st_q == S_IDLE) && in_full_q && out_free;

	nmt_vel_mem #(
		.NOTE_COUNT(NOTE_COUNT)
	) u_vel_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rd_vel (rd_vel)
	);

	always_comb begin
		st_d     = st_q;
		msg_d    = msg_q;
		fv_d     = fv_q;
		fval_d   = fval_q;
		played_d = played_q;
		held_d   = held_q;
		idx_d    = idx_q;
		ld_out   = 1'b0;
		done_d   = 1'b0;
		req      = '0;
		case (st_q)
			S_IDLE: begin
				if (proc) begin
					ld_out = 1'b1;
					if (in_byte_q[7]) begin
						msg_d = (in_byte_q[3:0] == listen_q) ? in_byte_q[7:4] : '0;
					end else if (msg_q == nmt_pkg::TYPE_NOTE_ON ||
							msg_q == nmt_pkg::TYPE_NOTE_OFF) begin
						if (!fv_q) begin
							fv_d   = 1'b1;
							fval_d = in_byte_q[6:0];
						end else begin
							msg_d       = '0;
							fv_d        = 1'b0;
							fval_d      = '0;
							done_d      = 1'b1;
							req.wr_en   = 1'b1;
							req.wr_addr = fval_q;
							if (msg_q == nmt_pkg::TYPE_NOTE_ON) begin
								req.wr_data = in_byte_q[6:0];
								if (held_q != nmt_pkg::CNT_MAX)
									held_d = held_q + 8'd1;
								if (fval_q > played_q)
									played_d = fval_q;
							end else begin
								req.wr_data = '0;
								if (held_q != '0) begin
									held_d = held_q - 8'd1;
									// released the played note: scan downward
									if (fval_q == played_q && fval_q != '0) begin
										ld_out = 1'b0;
										idx_d  = fval_q - 7'd1;
										st_d   = S_RD;
									end
								end
							end
						end
					end else begin
						msg_d = '0;
					end
				end
			end
			S_RD: begin
				req.rd_en   = 1'b1;
				req.rd_addr = idx_q;
				st_d        = S_CHK;
			end
			S_CHK: begin
				if (rd_vel != '0 || idx_q == '0) begin
					played_d = idx_q;
					ld_out   = 1'b1;
					done_d   = 1'b1;
					st_d     = S_IDLE;
				end else begin
					// check this entry while the next one is read
					idx_d       = idx_q - 7'd1;
					req.rd_en   = 1'b1;
					req.rd_addr = idx_q - 7'd1;
				end
			end
			default: begin
				st_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= S_IDLE;
			in_byte_q    <= '0;
			in_full_q    <= 1'b0;
			listen_q     <= '0;
			msg_q        <= '0;
			fv_q         <= 1'b0;
			fval_q       <= '0;
			played_q     <= '0;
			held_q       <= '0;
			idx_q        <= '0;
			out_valid_q  <= 1'b0;
			current_note <= '0;
			held_count   <= '0;
			message_done <= 1'b0;
		end else begin
			st_q     <= st_d;
			msg_q    <= msg_d;
			fv_q     <= fv_d;
			fval_q   <= fval_d;
			played_q <= played_d;
			held_q   <= held_d;
			idx_q    <= idx_d;
			if (cfg_valid)
				listen_q <= cfg_data;
			if (in_valid && !in_full_q) begin
				in_byte_q <= midi_byte;
				in_full_q <= 1'b1;
			end else if (proc) begin
				in_full_q <= 1'b0;
			end
			if (ld_out) begin
				out_valid_q  <= 1'b1;
				current_note <= played_d;
				held_count   <= held_d;
				message_done <= done_d;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`NMT_ASSERT_IMP(a_scan_out_empty, st_q == S_RD || st_q == S_CHK, !out_valid_q)
	`NMT_ASSERT_IMP(a_scan_below_played, st_q == S_RD || st_q == S_CHK, idx_q < played_q)
	`NMT_ASSERT_NXT(a_read_then_check, st_q == S_RD, st_q == S_CHK)
	`NMT_ASSERT_IMP(a_count_step, held_q != $past(held_q),
		held_q == $past(held_q) + 8'd1 || held_q == $past(held_q) - 8'd1)

endmodule

[rtl/nmt_vel_mem.sv]
// Velocity memory with per-entry valid bits and a registered read port.
module nmt_vel_mem #(
	parameter int NOTE_COUNT = nmt_pkg::NOTE_COUNT_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  nmt_pkg::nmt_mem_req_t      req,
	output logic [nmt_pkg::VEL_W-1:0]  rd_vel
);

	localparam int AW = $clog2(NOTE_COUNT);

	logic [nmt_pkg::VEL_W-1:0] mem [NOTE_COUNT];
	logic [NOTE_COUNT-1:0]     vld_q;
	logic [nmt_pkg::VEL_W-1:0] rd_data_s1;
	logic                      rd_vld_s1;
	logic                      wr_in_range;
	logic                      rd_in_range;

	assign wr_in_range = {1'b0, req.wr_addr} < (nmt_pkg::NOTE_W + 1)'(NOTE_COUNT);
	assign rd_in_range = {1'b0, req.rd_addr} < (nmt_pkg::NOTE_W + 1)'(NOTE_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (req.wr_en && wr_in_range)
				vld_q[req.wr_addr[AW-1:0]] <= 1'b1;
			if (req.rd_en)
				rd_vld_s1 <= rd_in_range && vld_q[req.rd_addr[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr_en && wr_in_range)
			mem[req.wr_addr[AW-1:0]] <= req.wr_data;
		if (req.rd_en)
			rd_data_s1 <= mem[req.rd_addr[AW-1:0]];
	end

	// an entry never written reads as zero
	assign rd_vel = rd_vld_s1 ? rd_data_s1 : '0;

endmodule
